// ===== rtl/core/ctp_pkg.sv =====
package ctp_pkg;

  localparam int unsigned SECTIONS = 3;
  localparam int unsigned CH_W     = 2;
  localparam int unsigned SAMPLE_W = 24;
  localparam int unsigned COEF_W   = 20;
  localparam int unsigned GAIN_W   = 24;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned ACC_W    = 56;
  localparam int unsigned CFG_W    = 32;
  localparam int unsigned IDX_W    = 3;

  localparam logic signed [WORD_W-1:0] CLIP_LIMIT = 32'sd6553600;
  localparam logic [GAIN_W-1:0]        GAIN_RESET = 24'd65536;

  typedef enum logic [IDX_W-1:0] {
    REG_COEF_A_FIRST  = 3'd0,
    REG_COEF_B_FIRST  = 3'd1,
    REG_COEF_A_SECOND = 3'd2,
    REG_COEF_B_SECOND = 3'd3,
    REG_COEF_A_THIRD  = 3'd4,
    REG_COEF_B_THIRD  = 3'd5,
    REG_INPUT_GAIN    = 3'd6
  } ctp_reg_e;

  // One sample moving down the chain; ok is low for a channel beyond the bank.
  typedef struct packed {
    logic                     valid;
    logic [CH_W-1:0]          ch;
    logic                     ok;
    logic signed [WORD_W-1:0] x;
  } ctp_beat_t;

  // Round to nearest with ties upward at Q16, then saturate to a 32-bit word.
  function automatic logic signed [WORD_W-1:0] round_sat(
    input logic signed [ACC_W-1:0] v
  );
    logic signed [ACC_W-1:0]    t;
    logic signed [ACC_W-17:0]   r;
    logic signed [WORD_W-1:0]   res;
    t = v + ACC_W'(32768);
    r = t[ACC_W-1:16];
    if (!r[ACC_W-17] && (|r[ACC_W-17:WORD_W-1])) begin
      res = {1'b0, {(WORD_W-1){1'b1}}};
    end else if (r[ACC_W-17] && !(&r[ACC_W-17:WORD_W-1])) begin
      res = {1'b1, {(WORD_W-1){1'b0}}};
    end else begin
      res = r[WORD_W-1:0];
    end
    return res;
  endfunction

endpackage

// ===== rtl/core/ctp_section_cell.sv =====
module ctp_section_cell #(
  parameter int unsigned CHANNELS = 4
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic signed [ctp_pkg::COEF_W-1:0]    coef_a_i,
  input  logic signed [ctp_pkg::COEF_W-1:0]    coef_b_i,
  input  ctp_pkg::ctp_beat_t                   beat_i,
  output ctp_pkg::ctp_beat_t                   beat_o
);

  localparam int unsigned CW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned PR_W = ctp_pkg::COEF_W + ctp_pkg::WORD_W;

  logic signed [ctp_pkg::WORD_W-1:0] y1_q [CHANNELS];
  logic signed [ctp_pkg::WORD_W-1:0] y2_q [CHANNELS];

  logic [CW+1:0] ch_ext;
  logic [CW-1:0] idx_in;

  // Multiply step.
  logic                              va_q;
  logic [ctp_pkg::CH_W-1:0]          cha_q;
  logic                              oka_q;
  logic [CW-1:0]                     idxa_q;
  logic signed [ctp_pkg::WORD_W-1:0] xa_q;
  logic signed [PR_W-1:0]            p1_q;
  logic signed [PR_W-1:0]            p2_q;

  // Accumulate and round step.
  logic signed [ctp_pkg::ACC_W-1:0]  acc;
  logic signed [ctp_pkg::WORD_W-1:0] y;
  logic                              ov_q;
  logic [ctp_pkg::CH_W-1:0]          och_q;
  logic                              ook_q;
  logic signed [ctp_pkg::WORD_W-1:0] ox_q;

  assign ch_ext = (CW+2)'(beat_i.ch);
  assign idx_in = ch_ext[CW-1:0];

  always_ff @(posedge clk_i) begin
    if (beat_i.valid) begin
      cha_q  <= beat_i.ch;
      oka_q  <= beat_i.ok;
      idxa_q <= idx_in;
      xa_q   <= beat_i.x;
      p1_q   <= coef_a_i * y1_q[idx_in];
      p2_q   <= coef_b_i * y2_q[idx_in];
    end
  end

  assign acc = (ctp_pkg::ACC_W'(xa_q) <<< 16) - ctp_pkg::ACC_W'(p1_q)
               - ctp_pkg::ACC_W'(p2_q);
  assign y   = ctp_pkg::round_sat(acc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      ov_q <= 1'b0;
      for (int i = 0; i < int'(CHANNELS); i++) begin
        y1_q[i] <= '0;
        y2_q[i] <= '0;
      end
    end else begin
      va_q <= beat_i.valid;
      ov_q <= va_q;
      if (va_q && oka_q) begin
        y1_q[idxa_q] <= y;
        y2_q[idxa_q] <= y1_q[idxa_q];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (va_q) begin
      och_q <= cha_q;
      ook_q <= oka_q;
      ox_q  <= y;
    end
  end

  assign beat_o = '{valid: ov_q, ch: och_q, ok: ook_q, x: ox_q};

endmodule

// ===== rtl/core/cascaded_two_pole_filter_bank.sv =====
// Channel  Direction  Handshake          Beat contents
// in       input      in_valid_i/stall   channel_i, sample_in_i
// out      output     out_valid_o/stall  channel_out_o, sample_out_o
// cfg      input      cfg_valid_i/ready  cfg_index_i, cfg_data_i
//
// From acceptance to out_valid_o a sample passes the gain multiply at the accepting edge, a
// register that rounds it, two in each of the three section cells, and the output register.
// One sample is in flight at a time; in_stall_o drops once its result sits in the output
// register. A stalled output holds one result while the next sample is accepted; a second
// result parks and keeps in_stall_o high until it moves on.
// Reset clears the filter history and coefficients and sets unity gain; cfg_ready_o is always high.
module cascaded_two_pole_filter_bank #(
  parameter int unsigned CHANNELS = 4
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [ctp_pkg::CH_W-1:0]              channel_i,
  input  logic signed [ctp_pkg::SAMPLE_W-1:0]   sample_in_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [ctp_pkg::CH_W-1:0]              channel_out_o,
  output logic signed [ctp_pkg::SAMPLE_W-1:0]   sample_out_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [ctp_pkg::IDX_W-1:0]             cfg_index_i,
  input  logic [ctp_pkg::CFG_W-1:0]             cfg_data_i
);

  localparam int unsigned PROD_W = ctp_pkg::SAMPLE_W + ctp_pkg::GAIN_W + 1;

  logic signed [ctp_pkg::COEF_W-1:0] coef_a_q [ctp_pkg::SECTIONS];
  logic signed [ctp_pkg::COEF_W-1:0] coef_b_q [ctp_pkg::SECTIONS];
  logic [ctp_pkg::GAIN_W-1:0]        gain_q;

  logic                              accept;
  logic                              busy_q;
  logic                              in_ok;

  logic                              pv_q;
  logic [ctp_pkg::CH_W-1:0]          pch_q;
  logic                              pok_q;
  logic signed [PROD_W-1:0]          prod_q;

  logic                              gv_q;
  logic [ctp_pkg::CH_W-1:0]          gch_q;
  logic                              gok_q;
  logic signed [ctp_pkg::WORD_W-1:0] gx_q;

  ctp_pkg::ctp_beat_t                chain [ctp_pkg::SECTIONS+1];
  ctp_pkg::ctp_beat_t                fin;
  ctp_pkg::ctp_beat_t                src;

  logic                              hv_q;
  logic [ctp_pkg::CH_W-1:0]          hch_q;
  logic                              hok_q;
  logic signed [ctp_pkg::WORD_W-1:0] hx_q;

  logic                              out_free;
  logic                              ov_q;
  logic [ctp_pkg::CH_W-1:0]          och_q;
  logic signed [ctp_pkg::SAMPLE_W-1:0] osmp_q;
  logic signed [ctp_pkg::WORD_W-1:0] clipped;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = busy_q;
  assign accept      = in_valid_i && !busy_q;
  assign in_ok       = (32'(channel_i) < CHANNELS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(ctp_pkg::SECTIONS); i++) begin
        coef_a_q[i] <= '0;
        coef_b_q[i] <= '0;
      end
      gain_q <= ctp_pkg::GAIN_RESET;
    end else if (cfg_valid_i) begin
      case (ctp_pkg::ctp_reg_e'(cfg_index_i))
        ctp_pkg::REG_COEF_A_FIRST:  coef_a_q[0] <= cfg_data_i[ctp_pkg::COEF_W-1:0];
        ctp_pkg::REG_COEF_B_FIRST:  coef_b_q[0] <= cfg_data_i[ctp_pkg::COEF_W-1:0];
        ctp_pkg::REG_COEF_A_SECOND: coef_a_q[1] <= cfg_data_i[ctp_pkg::COEF_W-1:0];
        ctp_pkg::REG_COEF_B_SECOND: coef_b_q[1] <= cfg_data_i[ctp_pkg::COEF_W-1:0];
        ctp_pkg::REG_COEF_A_THIRD:  coef_a_q[2] <= cfg_data_i[ctp_pkg::COEF_W-1:0];
        ctp_pkg::REG_COEF_B_THIRD:  coef_b_q[2] <= cfg_data_i[ctp_pkg::COEF_W-1:0];
        ctp_pkg::REG_INPUT_GAIN:    gain_q      <= cfg_data_i[ctp_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Gain multiply straight off the input beat, then round into the chain.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pch_q  <= channel_i;
      pok_q  <= in_ok;
      prod_q <= sample_in_i * $signed({1'b0, gain_q});
    end
    if (pv_q) begin
      gch_q <= pch_q;
      gok_q <= pok_q;
      gx_q  <= ctp_pkg::round_sat(ctp_pkg::ACC_W'(prod_q));
    end
  end

  assign chain[0] = '{valid: gv_q, ch: gch_q, ok: gok_q, x: gx_q};

  for (genvar s = 0; s < ctp_pkg::SECTIONS; s++) begin : g_cell
    ctp_section_cell #(
      .CHANNELS(CHANNELS)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .coef_a_i(coef_a_q[s]),
      .coef_b_i(coef_b_q[s]),
      .beat_i  (chain[s]),
      .beat_o  (chain[s+1])
    );
  end

  assign fin      = chain[ctp_pkg::SECTIONS];
  assign out_free = !ov_q || !out_stall_i;
  assign src      = fin.valid ? fin : '{valid: hv_q, ch: hch_q, ok: hok_q, x: hx_q};

  always_comb begin
    if (!src.ok) begin
      clipped = '0;
    end else if (src.x > ctp_pkg::CLIP_LIMIT) begin
      clipped = ctp_pkg::CLIP_LIMIT;
    end else if (src.x < -ctp_pkg::CLIP_LIMIT) begin
      clipped = -ctp_pkg::CLIP_LIMIT;
    end else begin
      clipped = src.x;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pv_q   <= 1'b0;
      gv_q   <= 1'b0;
      hv_q   <= 1'b0;
      ov_q   <= 1'b0;
    end else begin
      pv_q <= accept;
      gv_q <= pv_q;
      if (fin.valid && !out_free) begin
        hv_q <= 1'b1;
      end else if (out_free) begin
        hv_q <= 1'b0;
      end
      if (out_free) begin
        ov_q <= src.valid;
      end
      if (accept) begin
        busy_q <= 1'b1;
      end else if (out_free && src.valid) begin
        busy_q <= 1'b0;
      end
    end
  end

  // A finished result parks here while the output is held; the output register also loads here.
  always_ff @(posedge clk_i) begin
    if (fin.valid && !out_free) begin
      hch_q <= fin.ch;
      hok_q <= fin.ok;
      hx_q  <= fin.x;
    end
    if (out_free && src.valid) begin
      och_q  <= src.ch;
      osmp_q <= clipped[ctp_pkg::SAMPLE_W-1:0];
    end
  end

  assign out_valid_o   = ov_q;
  assign channel_out_o = och_q;
  assign sample_out_o  = osmp_q;

endmodule

// ===== rtl/core/ctp_checker.sv =====
module ctp_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_stall_o,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic [ctp_pkg::CH_W-1:0]            channel_out_o,
  input logic signed [ctp_pkg::SAMPLE_W-1:0] sample_out_o
);

  logic       in_beat;
  logic       out_beat;
  logic [2:0] pend_q;

  assign in_beat  = in_valid_i && !in_stall_o;
  assign out_beat = out_valid_o && !out_stall_i;

  // Samples accepted whose results have not yet been taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 3'(in_beat) - 3'(out_beat);
    end
  end

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> in_stall_o)
    else $error("sample accepted while another is in the filter");

  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(sample_out_o) && $stable(channel_out_o)))
    else $error("stalled output beat changed");

  a_out_clipped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (sample_out_o <= 24'sd6553600 && sample_out_o >= -24'sd6553600))
    else $error("output outside the clip range");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pend_q != 3'd0))
    else $error("output beat without an accepted sample");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= 3'd2)
    else $error("more samples outstanding than the filter can hold");

endmodule

bind cascaded_two_pole_filter_bank ctp_checker u_ctp_checker (.*);

// ===== verif/cascaded_two_pole_filter_bank_test.sv =====
module cascaded_two_pole_filter_bank_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ctp_pkg::*;

  localparam int unsigned NUM_CH       = 4;
  localparam int          STUCK_LIMIT  = 4000;
  localparam int          SETTLE_CYCLES = 16;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          PHASES       = 8;
  localparam int          PHASE_ITEMS  = 185;

  localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;

  localparam ctp_reg_e A_REG [SECTIONS] = '{REG_COEF_A_FIRST, REG_COEF_A_SECOND,
                                            REG_COEF_A_THIRD};
  localparam ctp_reg_e B_REG [SECTIONS] = '{REG_COEF_B_FIRST, REG_COEF_B_SECOND,
                                            REG_COEF_B_THIRD};

  // Coefficient settings used per phase.
  localparam int CFG_STABLE  = 0;
  localparam int CFG_EXTREME = 1;
  localparam int CFG_RANDOM  = 2;
  localparam int CFG_BYPASS  = 3;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7FFFFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 24'sh800000;
  localparam logic signed [COEF_W-1:0]   COEF_MAX   = 20'sh7FFFF;
  localparam logic signed [COEF_W-1:0]   COEF_MIN   = 20'sh80000;
  localparam logic [GAIN_W-1:0]          GAIN_MAX   = 24'hFFFFFF;
  localparam longint                     WORD_MAX   = 64'sd2147483647;
  localparam longint                     WORD_MIN   = -64'sd2147483648;

  typedef struct {
    logic [CH_W-1:0]              ch;
    logic signed [SAMPLE_W-1:0]   value;
  } filtered_t;

  class filter_bank_scoreboard;
    logic signed [COEF_W-1:0] coef_a [SECTIONS];
    logic signed [COEF_W-1:0] coef_b [SECTIONS];
    logic [GAIN_W-1:0]        gain;
    // Per channel and section: index 0 is the last output, 1 the one before.
    int                       history [NUM_CH][SECTIONS][2];
    filtered_t                due[$];
    int unsigned              samples_taken;
    int unsigned              results_checked;
    int unsigned              mismatches;

    function new();
      foreach (coef_a[i]) begin
        coef_a[i] = '0;
        coef_b[i] = '0;
      end
      foreach (history[c, s, k]) history[c][s][k] = 0;
      gain = GAIN_RESET;
      samples_taken = 0;
      results_checked = 0;
      mismatches = 0;
    endfunction

    // Nearest at Q16, ties toward plus infinity.
    function longint round_half_up(longint v);
      return (v + 64'sd32768) >>> 16;
    endfunction

    function longint clamp_word(longint v);
      if (v > WORD_MAX) return WORD_MAX;
      if (v < WORD_MIN) return WORD_MIN;
      return v;
    endfunction

    function void load_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_COEF_A_FIRST:  coef_a[0] = data[COEF_W-1:0];
        REG_COEF_B_FIRST:  coef_b[0] = data[COEF_W-1:0];
        REG_COEF_A_SECOND: coef_a[1] = data[COEF_W-1:0];
        REG_COEF_B_SECOND: coef_b[1] = data[COEF_W-1:0];
        REG_COEF_A_THIRD:  coef_a[2] = data[COEF_W-1:0];
        REG_COEF_B_THIRD:  coef_b[2] = data[COEF_W-1:0];
        REG_INPUT_GAIN:    gain = data[GAIN_W-1:0];
        default: ;
      endcase
    endfunction

    function void take_sample(logic [CH_W-1:0] ch, logic signed [SAMPLE_W-1:0] value);
      longint    x;
      longint    acc;
      filtered_t f;
      samples_taken++;
      f.ch = ch;
      f.value = '0;
      if (ch < NUM_CH) begin
        x = clamp_word(round_half_up(longint'(value) * longint'(gain)));
        for (int sec = 0; sec < SECTIONS; sec++) begin
          acc = x * 65536 - longint'(coef_a[sec]) * history[ch][sec][0]
                - longint'(coef_b[sec]) * history[ch][sec][1];
          x = clamp_word(round_half_up(acc));
          history[ch][sec][1] = history[ch][sec][0];
          history[ch][sec][0] = int'(x);
        end
        if (x > CLIP_LIMIT) x = CLIP_LIMIT;
        else if (x < -CLIP_LIMIT) x = -CLIP_LIMIT;
        f.value = x[SAMPLE_W-1:0];
      end
      due.push_back(f);
    endfunction

    function void check_output(logic [CH_W-1:0] ch, logic signed [SAMPLE_W-1:0] value);
      filtered_t f;
      if (due.size() == 0) begin
        $error("output beat with no sample outstanding: channel %0d, sample_out %0d",
               ch, value);
        mismatches++;
        return;
      end
      f = due.pop_front();
      results_checked++;
      if (ch !== f.ch) begin
        $error("channel_out: expected %0d, actual %0d", f.ch, ch);
        mismatches++;
      end
      if (value !== f.value) begin
        $error("sample_out: expected %0d, actual %0d", f.value, value);
        mismatches++;
      end
    endfunction
  endclass

  logic                        clk_i;
  logic                        rst_ni;
  logic                        in_valid_i;
  logic                        in_stall_o;
  logic [CH_W-1:0]             channel_i;
  logic signed [SAMPLE_W-1:0]  sample_in_i;
  logic                        out_valid_o;
  logic                        out_stall_i;
  logic [CH_W-1:0]             channel_out_o;
  logic signed [SAMPLE_W-1:0]  sample_out_o;
  logic                        cfg_valid_i;
  logic                        cfg_ready_o;
  logic [IDX_W-1:0]            cfg_index_i;
  logic [CFG_W-1:0]            cfg_data_i;

  filter_bank_scoreboard board;
  logic                  no_gaps;
  logic                  hold_req;
  int                    stuck_cycles;
  int                    settings_used;

  cascaded_two_pole_filter_bank #(
    .CHANNELS(NUM_CH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .channel_i    (channel_i),
    .sample_in_i  (sample_in_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .channel_out_o(channel_out_o),
    .sample_out_o (sample_out_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Receiver: random stalls, plus a long hold-off when one is requested.
  initial begin
    int hold_left;
    hold_left = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req && hold_left == 0) begin
        hold_left = HOLD_CYCLES;
        hold_req <= 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !no_gaps && ($urandom_range(99) < 11);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      board.check_output(channel_out_o, sample_out_o);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("cascaded_two_pole_filter_bank_test: done, errors");
      $finish;
    end
  end

  // Called at a falling edge; returns at a falling edge with valid possibly
  // still high so the next beat can follow without a gap.
  task automatic send_sample(input logic [CH_W-1:0] ch,
                             input logic signed [SAMPLE_W-1:0] value);
    in_valid_i  <= 1'b1;
    channel_i   <= ch;
    sample_in_i <= value;
    do @(posedge clk_i); while (in_stall_o);
    board.take_sample(ch, value);
    @(negedge clk_i);
    if (!no_gaps) begin
      while ($urandom_range(99) < 11) begin
        in_valid_i <= 1'b0;
        @(negedge clk_i);
      end
    end
  endtask

  // Bits above the register width carry random junk; the block must drop them.
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    logic [CFG_W-1:0] mask;
    logic [CFG_W-1:0] word;
    mask = (idx == REG_INPUT_GAIN) ? ((CFG_W'(1) << GAIN_W) - 1)
                                   : ((CFG_W'(1) << COEF_W) - 1);
    word = (CFG_W'($urandom()) & ~mask) | (val & mask);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= word;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.load_reg(idx, word);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.due.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic configure(input int mode);
    logic signed [COEF_W-1:0] a;
    logic signed [COEF_W-1:0] b;
    logic [GAIN_W-1:0]        g;
    for (int sec = 0; sec < SECTIONS; sec++) begin
      case (mode)
        CFG_STABLE: begin
          a = COEF_W'($urandom_range(0, 262143) - 131072);
          b = COEF_W'($urandom_range(0, 60000));
        end
        CFG_EXTREME: begin
          a = $urandom_range(1) ? COEF_MAX : COEF_MIN;
          b = $urandom_range(1) ? COEF_MAX : COEF_MIN;
        end
        CFG_RANDOM: begin
          a = COEF_W'($urandom());
          b = COEF_W'($urandom());
        end
        default: begin
          a = '0;
          b = '0;
        end
      endcase
      write_reg(A_REG[sec], CFG_W'(a));
      write_reg(B_REG[sec], CFG_W'(b));
    end
    case (mode)
      CFG_STABLE:  g = GAIN_W'($urandom_range(8192, 131072));
      CFG_EXTREME: g = $urandom_range(1) ? GAIN_MAX : '0;
      default:     g = GAIN_W'($urandom());
    endcase
    write_reg(REG_INPUT_GAIN, CFG_W'(g));
    if ($urandom_range(1)) write_reg(REG_UNUSED, $urandom());
    cfg_valid_i <= 1'b0;
    settings_used++;
  endtask

  initial begin
    logic [CH_W-1:0]            ch;
    logic signed [SAMPLE_W-1:0] value;
    int                         pick;

    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    channel_i     = '0;
    sample_in_i   = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    no_gaps       = 1'b0;
    hold_req      = 1'b0;
    stuck_cycles  = 0;
    settings_used = 1;
    board = new();

    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset settings: unity gain and zero coefficients, so the output is the
    // input clipped to the output range.
    send_sample(0, SAMPLE_MAX);
    send_sample(1, SAMPLE_MIN);
    send_sample(2, 0);
    send_sample(3, 1);
    send_sample(0, -1);
    send_sample(1, CLIP_LIMIT[SAMPLE_W-1:0]);
    send_sample(2, 24'sd6553601);
    send_sample(3, -24'sd6553601);
    send_sample(0, 24'sd32768);
    drain();

    // Extreme coefficients and full gain, so the sections can be driven into saturation.
    write_reg(REG_COEF_A_FIRST, CFG_W'(COEF_MIN));
    write_reg(REG_COEF_B_FIRST, CFG_W'(COEF_MAX));
    write_reg(REG_COEF_A_SECOND, CFG_W'(COEF_MAX));
    write_reg(REG_COEF_B_SECOND, CFG_W'(COEF_MIN));
    write_reg(REG_COEF_A_THIRD, CFG_W'(COEF_MIN));
    write_reg(REG_COEF_B_THIRD, CFG_W'(COEF_MIN));
    write_reg(REG_INPUT_GAIN, CFG_W'(GAIN_MAX));
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    cfg_valid_i <= 1'b0;
    settings_used++;
    send_sample(0, SAMPLE_MAX);
    send_sample(0, SAMPLE_MAX);
    send_sample(0, SAMPLE_MAX);
    send_sample(0, SAMPLE_MIN);
    send_sample(0, SAMPLE_MIN);
    send_sample(1, 1);
    send_sample(2, -1);
    send_sample(3, SAMPLE_MIN);
    send_sample(1, SAMPLE_MAX);
    drain();

    ch = '0;
    for (int phase = 0; phase < PHASES; phase++) begin
      configure(phase % 4);
      no_gaps = (phase == 2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 5 && n == 40) hold_req <= 1'b1;
        if (phase == 6 && n == 90) drain();
        // Channels come in runs, as a real multi-channel stream would.
        if ($urandom_range(3) == 0) ch = CH_W'($urandom_range(NUM_CH - 1));
        pick = $urandom_range(99);
        if (pick < 55) begin
          value = SAMPLE_W'($urandom());
        end else if (pick < 85) begin
          value = SAMPLE_W'($urandom_range(0, 2097152) - 1048576);
        end else begin
          case ($urandom_range(5))
            0: value = SAMPLE_MAX;
            1: value = SAMPLE_MIN;
            2: value = 0;
            3: value = CLIP_LIMIT[SAMPLE_W-1:0];
            4: value = -CLIP_LIMIT[SAMPLE_W-1:0];
            default: value = -1;
          endcase
        end
        send_sample(ch, value);
      end
      drain();
    end
    no_gaps = 1'b0;

    $display("covered %0d samples over %0d register settings, %0d filtered outputs checked",
             board.samples_taken, settings_used, board.results_checked);
    if (board.mismatches == 0 && board.due.size() == 0) begin
      $display("cascaded_two_pole_filter_bank_test: done, clean");
    end else begin
      $display("cascaded_two_pole_filter_bank_test: done, errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/ctp_pkg.sv
rtl/core/ctp_section_cell.sv
rtl/core/cascaded_two_pole_filter_bank.sv
rtl/core/ctp_checker.sv
verif/cascaded_two_pole_filter_bank_test.sv
